// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, constants, sector codes and stage records shared by the
// HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W   = 9;
    localparam int CH_W    = 8;
    localparam int K_W     = 6;
    localparam int SECT_W  = 3;
    localparam int PROD_W  = 2 * CH_W;
    localparam int N_W     = 14;
    localparam int Y_W     = N_W - 2;
    localparam int Q_W     = 24;

    localparam logic [HUE_W-1:0] HUE_MAX   = 9'd360;
    localparam logic [K_W-1:0]   SECT_SPAN = 6'd60;
    localparam logic [PROD_W:0]  RND_255   = 17'd128;
    localparam logic [N_W-1:0]   X_BIAS    = 14'd30;
    // floor(y / 15) == (y * 2185) >> 15 for every y below 3833
    localparam logic [Y_W-1:0]   RECIP_15    = 12'd2185;
    localparam int               RECIP_SHIFT = 15;

    localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;
    localparam logic [SECT_W-1:0] SECT_WRAP    = 3'd6;

    typedef struct packed {
        logic [CH_W-1:0]   c;
        logic [K_W-1:0]    k;
        logic [SECT_W-1:0] sect;
        logic [CH_W-1:0]   v;
        logic              inv;
    } t_chroma;

    typedef struct packed {
        logic [CH_W-1:0]   x;
        logic [CH_W-1:0]   c;
        logic [CH_W-1:0]   m;
        logic [SECT_W-1:0] sect;
        logic              inv;
    } t_xterm;

    // first hue of each 60-degree sector
    function automatic logic [HUE_W-1:0] sector_base(input logic [SECT_W-1:0] sect);
        logic [HUE_W-1:0] base;
        unique case (sect)
            SECT_RED_YEL: base = 9'd0;
            SECT_YEL_GRN: base = 9'd60;
            SECT_GRN_CYN: base = 9'd120;
            SECT_CYN_BLU: base = 9'd180;
            SECT_BLU_MAG: base = 9'd240;
            SECT_MAG_RED: base = 9'd300;
            SECT_WRAP:    base = 9'd360;
            default:      base = 9'd360;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hsv2rgb_hsv_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// Valid/ready channel carrying one HSV pixel word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_hsv_if
    import hsv2rgb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/hsv2rgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// Valid/ready channel carrying one RGB pixel word with its invalid flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv2rgb_rgb_if
    import hsv2rgb_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            invalid;

    modport source (output valid, output red, output green, output blue,
                    output invalid, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsv2rgb_chroma.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_chroma
// Stages 1-2: hue sector and ramp, s*v product, then chroma rounded
// to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_chroma
    import hsv2rgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [HUE_W-1:0] i_hue,
    input  wire logic [CH_W-1:0]  i_sat,
    input  wire logic [CH_W-1:0]  i_val,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_chroma               o_word
);

    logic              r_vld1, r_vld2;
    logic              w_rdy1, w_rdy2;

    logic [PROD_W-1:0] r_prod1;
    logic [K_W-1:0]    r_k1;
    logic [SECT_W-1:0] r_sect1;
    logic [CH_W-1:0]   r_v1;
    logic              r_inv1;

    t_chroma           r_word2;

    logic [SECT_W-1:0] n_sect;
    logic [HUE_W-1:0]  w_off;
    logic [K_W-1:0]    w_d;
    logic [K_W-1:0]    n_k;
    logic [PROD_W-1:0] n_prod;
    logic [PROD_W:0]   w_pp;
    logic [PROD_W:0]   w_sum;
    logic [CH_W-1:0]   n_c;

    assign w_rdy2  = !r_vld2 || i_ready;
    assign w_rdy1  = !r_vld1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_vld2;
    assign o_word  = r_word2;

    // stage 1
    always_comb begin
        priority if (i_hue >= 9'd360) n_sect = SECT_WRAP;
        else if (i_hue >= 9'd300)     n_sect = SECT_MAG_RED;
        else if (i_hue >= 9'd240)     n_sect = SECT_BLU_MAG;
        else if (i_hue >= 9'd180)     n_sect = SECT_CYN_BLU;
        else if (i_hue >= 9'd120)     n_sect = SECT_GRN_CYN;
        else if (i_hue >= 9'd60)      n_sect = SECT_YEL_GRN;
        else                          n_sect = SECT_RED_YEL;
    end

    // ramp k rises in even sectors and falls in odd ones
    assign w_off  = i_hue - sector_base(n_sect);
    assign w_d    = w_off[K_W-1:0];
    assign n_k    = n_sect[0] ? (SECT_SPAN - w_d) : w_d;
    assign n_prod = PROD_W'(i_sat) * PROD_W'(i_val);

    // stage 2: round(p / 255) as (p + 128 + ((p + 128) >> 8)) >> 8
    assign w_pp  = {1'b0, r_prod1} + RND_255;
    assign w_sum = w_pp + (w_pp >> CH_W);
    assign n_c   = w_sum[2*CH_W-1:CH_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_rdy1) r_vld1 <= i_valid;
            if (w_rdy2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_prod1 <= n_prod;
            r_k1    <= n_k;
            r_sect1 <= n_sect;
            r_v1    <= i_val;
            r_inv1  <= (i_hue > HUE_MAX);
        end
        if (w_rdy2) begin
            r_word2.c    <= n_c;
            r_word2.k    <= r_k1;
            r_word2.sect <= r_sect1;
            r_word2.v    <= r_v1;
            r_word2.inv  <= r_inv1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_xterm.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_xterm
// Stages 3-4: x = round(c * k / 60) via c*k product then a reciprocal
// multiply; also forms the offset m = v - c.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_xterm
    import hsv2rgb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_chroma i_word,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_xterm       o_word
);

    logic              r_vld3, r_vld4;
    logic              w_rdy3, w_rdy4;

    logic [N_W-1:0]    r_n3;
    logic [CH_W-1:0]   r_c3;
    logic [CH_W-1:0]   r_m3;
    logic [SECT_W-1:0] r_sect3;
    logic              r_inv3;

    t_xterm            r_word4;

    logic [N_W-1:0]    n_n;
    logic [Q_W-1:0]    n_q;

    assign w_rdy4  = !r_vld4 || i_ready;
    assign w_rdy3  = !r_vld3 || w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_vld4;
    assign o_word  = r_word4;

    // (c*k + 30) / 60 == ((c*k + 30) >> 2) / 15
    assign n_n = N_W'(i_word.c) * N_W'(i_word.k) + X_BIAS;
    assign n_q = Q_W'(r_n3[N_W-1:2]) * Q_W'(RECIP_15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (w_rdy3) r_vld3 <= i_valid;
            if (w_rdy4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_n3    <= n_n;
            r_c3    <= i_word.c;
            r_m3    <= i_word.v - i_word.c;
            r_sect3 <= i_word.sect;
            r_inv3  <= i_word.inv;
        end
        if (w_rdy4) begin
            r_word4.x    <= n_q[RECIP_SHIFT +: CH_W];
            r_word4.c    <= r_c3;
            r_word4.m    <= r_m3;
            r_word4.sect <= r_sect3;
            r_word4.inv  <= r_inv3;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsv2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stage 5: places c and x by sector, adds the offset, blanks invalid
// hues, and holds the result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_xterm i_word,
    hsv2rgb_rgb_if.source o_pix
);

    logic            r_vld;
    logic            w_rdy;
    logic [CH_W-1:0] r_red, r_green, r_blue;
    logic            r_inv;

    logic [CH_W-1:0] w_r, w_g, w_b;
    logic [CH_W-1:0] n_red, n_green, n_blue;

    assign w_rdy   = !r_vld || o_pix.ready;
    assign o_ready = w_rdy;

    always_comb begin
        unique case (i_word.sect)
            SECT_RED_YEL: begin w_r = i_word.c; w_g = i_word.x; w_b = '0;       end
            SECT_YEL_GRN: begin w_r = i_word.x; w_g = i_word.c; w_b = '0;       end
            SECT_GRN_CYN: begin w_r = '0;       w_g = i_word.c; w_b = i_word.x; end
            SECT_CYN_BLU: begin w_r = '0;       w_g = i_word.x; w_b = i_word.c; end
            SECT_BLU_MAG: begin w_r = i_word.x; w_g = '0;       w_b = i_word.c; end
            // last sector and hue 360 share one placement
            default:      begin w_r = i_word.c; w_g = '0;       w_b = i_word.x; end
        endcase
    end

    assign n_red   = i_word.inv ? '0 : w_r + i_word.m;
    assign n_green = i_word.inv ? '0 : w_g + i_word.m;
    assign n_blue  = i_word.inv ? '0 : w_b + i_word.m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_inv   <= i_word.inv;
        end
    end

    assign o_pix.valid   = r_vld;
    assign o_pix.red     = r_red;
    assign o_pix.green   = r_green;
    assign o_pix.blue    = r_blue;
    assign o_pix.invalid = r_inv;

endmodule

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to RGB pixel converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one HSV word per handshake: hue in degrees (0..360 valid),
//   saturation and brightness as 8-bit fractions where 255 is 1.0.
//   o_pix returns one RGB word per input word, in order. A hue above 360
//   gives invalid = 1 with red, green and blue all zero.
//   A word accepted into stage 1 moves through stages 2, 3 and 4 to the
//   stage 5 output register and is presented on o_pix from there.
//   Throughput is one word per clock while o_pix.ready stays high; the two
//   multiplies of the x term (c*k, then the reciprocal of 15) and the s*v
//   product each sit in their own stage.
//   Each stage holds its word while the stage after it is full and stalled,
//   so a low o_pix.ready backs up stage by stage into i_pix.ready; empty
//   stages still fill, so up to five words are held at a stall.
//   Reset (i_rst_n low, synchronous) empties every stage; no word is
//   presented until new input arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hsv2rgb_hsv_if.sink   i_pix,
    hsv2rgb_rgb_if.source o_pix
);

    logic    w_chroma_valid, w_chroma_ready;
    t_chroma w_chroma;
    logic    w_xterm_valid, w_xterm_ready;
    t_xterm  w_xterm;

    hsv2rgb_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_hue   (i_pix.hue),
        .i_sat   (i_pix.saturation),
        .i_val   (i_pix.brightness),
        .o_valid (w_chroma_valid),
        .i_ready (w_chroma_ready),
        .o_word  (w_chroma)
    );

    hsv2rgb_xterm u_xterm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_chroma_valid),
        .o_ready (w_chroma_ready),
        .i_word  (w_chroma),
        .o_valid (w_xterm_valid),
        .i_ready (w_xterm_ready),
        .o_word  (w_xterm)
    );

    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xterm_valid),
        .o_ready (w_xterm_ready),
        .i_word  (w_xterm),
        .o_pix   (o_pix)
    );

`ifndef SYNTHESIS
    a_chroma_le_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chroma_valid |-> (w_chroma.c <= w_chroma.v))
        else $error("chroma exceeds value");

    // ramp and x term are don't-care for out-of-range hues
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_chroma_valid && !w_chroma.inv) |-> (w_chroma.k <= SECT_SPAN))
        else $error("hue ramp out of range");

    a_xterm_le_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_xterm_valid && !w_xterm.inv) |-> (w_xterm.x <= w_xterm.c))
        else $error("x term exceeds chroma");

    a_invalid_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.invalid) |->
            (o_pix.red == '0 && o_pix.green == '0 && o_pix.blue == '0))
        else $error("invalid hue word carries color");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_pix.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Drives HSV words through the converter and compares every RGB word with a
// literal result from the directed table or with a local fixed-point model of
// the conversion. A directed table covers the primaries, sector edges, the 360
// wrap and out-of-range hues. Random words follow under four idle/stall mixes.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_tb;
    import hsv2rgb_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int WORDS_PER_MIX  = 432;
    localparam int DRAIN_CYCLES   = 16;
    localparam int N_DIRECTED     = 23;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            invalid;
    } t_rgb_word;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  bri;
        logic             has_lit;
        t_rgb_word        lit;
    } t_hsv_row;

    // literal results only where they are obvious; the rest go to the model
    localparam t_hsv_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{9'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
        '{9'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{9'd60,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
        '{9'd120, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
        '{9'd180, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
        '{9'd240, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
        '{9'd300, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
        '{9'd360, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
        '{9'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
        '{9'd200, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128, 1'b0}},
        '{9'd361, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd511, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd480, 8'd170, 8'd85,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
        '{9'd30,  8'd255, 8'd255, 1'b0, '0},
        '{9'd59,  8'd255, 8'd128, 1'b0, '0},
        '{9'd61,  8'd128, 8'd255, 1'b0, '0},
        '{9'd119, 8'd1,   8'd255, 1'b0, '0},
        '{9'd179, 8'd255, 8'd1,   1'b0, '0},
        '{9'd239, 8'd170, 8'd85,  1'b0, '0},
        '{9'd299, 8'd85,  8'd170, 1'b0, '0},
        '{9'd359, 8'd200, 8'd100, 1'b0, '0},
        '{9'd256, 8'd127, 8'd254, 1'b0, '0},
        '{9'd90,  8'd128, 8'd128, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    hsv2rgb_hsv_if pix_in ();
    hsv2rgb_rgb_if pix_out ();

    hsv_to_rgb_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in.sink),
        .o_pix   (pix_out.source)
    );

    t_rgb_word pending_rgb [$];
    int        send_idle_pct;
    int        stall_pct;
    int        err_count;
    int        cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // c = s*v/255, x = c*k/60 with k the distance from the nearest multiple
    // of 120 folded at 60; both rounded half up
    function automatic t_rgb_word convert_hsv(input logic [HUE_W-1:0] hue,
                                              input logic [CH_W-1:0] sat,
                                              input logic [CH_W-1:0] bri);
        int unsigned       s_val, v_val, chroma, xterm, offset, phase, ramp;
        int unsigned       r, g, b;
        logic [SECT_W-1:0] sect;
        t_rgb_word         w;
        w = '0;
        if (hue > HUE_MAX) begin
            w.invalid = 1'b1;
            return w;
        end
        s_val  = sat;
        v_val  = bri;
        chroma = (2 * s_val * v_val + 255) / 510;
        phase  = hue % 120;
        ramp   = (phase >= 60) ? (120 - phase) : phase;
        xterm  = (2 * chroma * ramp + 60) / 120;
        offset = v_val - chroma;
        sect   = SECT_W'(hue / 60);
        case (sect)
            SECT_RED_YEL: begin r = chroma; g = xterm;  b = 0;      end
            SECT_YEL_GRN: begin r = xterm;  g = chroma; b = 0;      end
            SECT_GRN_CYN: begin r = 0;      g = chroma; b = xterm;  end
            SECT_CYN_BLU: begin r = 0;      g = xterm;  b = chroma; end
            SECT_BLU_MAG: begin r = xterm;  g = 0;      b = chroma; end
            default:      begin r = chroma; g = 0;      b = xterm;  end
        endcase
        w.red   = CH_W'(r + offset);
        w.green = CH_W'(g + offset);
        w.blue  = CH_W'(b + offset);
        return w;
    endfunction

    function automatic logic [HUE_W-1:0] pick_hue();
        int unsigned sel, edge_hue;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            return HUE_W'($urandom_range(361, 511));
        end else if (sel < 25) begin
            // around a sector boundary
            edge_hue = $urandom_range(0, 6) * 60 + $urandom_range(0, 2);
            return HUE_W'((edge_hue == 0) ? 0 : edge_hue - 1);
        end
        return HUE_W'($urandom_range(0, 360));
    endfunction

    function automatic logic [CH_W-1:0] pick_chan();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return '0;
        else if (sel < 16)
            return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // entered and left at a falling edge; the expectation is queued once
    // the word has been taken
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [CH_W-1:0] sat,
                              input logic [CH_W-1:0] bri, input logic has_lit,
                              input t_rgb_word lit);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= hue;
        pix_in.saturation <= sat;
        pix_in.brightness <= bri;
        do begin
            @(posedge i_clk);
            taken = pix_in.ready;
            @(negedge i_clk);
        end while (!taken);
        pending_rgb.insert(pending_rgb.size(), has_lit ? lit : convert_hsv(hue, sat, bri));
    endtask

    task automatic settle_pending();
        pix_in.valid <= 1'b0;
        do @(negedge i_clk); while (pending_rgb.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(negedge i_clk)
        pix_out.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge i_clk) begin
        t_rgb_word want;
        if (pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h %h %h %b", $time,
                         pix_out.red, pix_out.green, pix_out.blue, pix_out.invalid);
                err_count++;
            end else begin
                want = pending_rgb.pop_front();
                check_field("red",     want.red,     pix_out.red);
                check_field("green",   want.green,   pix_out.green);
                check_field("blue",    want.blue,    pix_out.blue);
                check_field("invalid", CH_W'(want.invalid), CH_W'(pix_out.invalid));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("hsv_to_rgb_converter_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        pix_in.valid      = 1'b0;
        pix_in.hue        = '0;
        pix_in.saturation = '0;
        pix_in.brightness = '0;
        pix_out.ready     = 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        err_count         = 0;
        cycle_count       = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED_ROWS[i])
            send_pixel(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].bri,
                       DIRECTED_ROWS[i].has_lit, DIRECTED_ROWS[i].lit);
        settle_pending();

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 47; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 47; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < WORDS_PER_MIX; n++)
                send_pixel(pick_hue(), pick_chan(), pick_chan(), 1'b0, '0);
            // hold off until the pipe is empty before the next mix
            settle_pending();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("hsv_to_rgb_converter_tb: done, clean");
        else
            $display("hsv_to_rgb_converter_tb: done, errors");
        $finish;
    end

endmodule
